@@ design/ordered_set_table_core_macros.svh @@
// Assertion macros used by the checker of the ordered set table.
`ifndef ORDERED_SET_TABLE_CORE_MACROS_SVH
`define ORDERED_SET_TABLE_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk and held off while rst is high.
`define OST_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked at the table's result latency after the antecedent.
`define OST_ASSERT_LAT2(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) \
    else $error(msg);

`endif

@@ design/ost_pkg.sv @@
// Shared types and constants of the ordered set table.
package ost_pkg;

  // Default capacity of the table.
  localparam int OST_ENTRIES = 32;

  // Field widths fixed by the interface.
  localparam int VALUE_W     = 32;
  localparam int CMD_W       = 2;
  localparam int COUNT_OUT_W = 6;

  // Command codes carried on the command port.
  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_CLEAR  = 2'd3
  } ost_cmd_t;

  // Broadcast from the controller to every cell of the chain.
  typedef struct packed {
    logic               remove_go;
    logic [VALUE_W-1:0] value;
  } ost_bcast_t;

endpackage

@@ design/ost_cell.sv @@
// One cell of the table chain: holds an entry, compares it, and shifts down on removal.
module ost_cell
  import ost_pkg::*;
(
  input  logic               clk,
  input  ost_bcast_t         bcast,
  input  logic               occupied,
  input  logic               write_here,
  input  logic               shift_in,
  input  logic [VALUE_W-1:0] next_entry,
  output logic [VALUE_W-1:0] entry,
  output logic               shift_out
);

  logic match;

  // A cell matches only while it holds a live entry.
  assign match     = occupied && (entry == bcast.value);
  // The match flag ripples upward so every cell above the hit knows to shift.
  assign shift_out = shift_in | match;

  // Append writes the broadcast value; a removal pulls in the upper neighbor's entry.
  always_ff @(posedge clk) begin
    if (write_here) begin
      entry <= bcast.value;
    end else if (bcast.remove_go && shift_out) begin
      entry <= next_entry;
    end
  end

endmodule

@@ design/ordered_set_table_core.sv @@
// Top level of the ordered set table: command register, cell chain and result register.
//
//   Channel  | Handshake        | Payload
//   ---------+------------------+---------------------------------------------
//   command  | start / busy     | command, value
//   result   | done (strobe)    | success, full_reject, entry_count, empty_res
//
// A transaction is accepted when start is high and busy is low; one command is taken
// every cycle while busy is low. Its result appears on done, for one cycle, once it has
// passed the command register and the result register. While it sits in the command
// register, every cell compares in parallel and the match flag ripples up the chain.
// busy is set by reset and cleared by the first clock edge that sees rst low.
// The receiver cannot stall, so results never back up.
module ordered_set_table_core
  import ost_pkg::*;
#(
  parameter int ENTRIES = OST_ENTRIES
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [CMD_W-1:0]       command,
  input  logic signed [VALUE_W-1:0] value,
  output logic                   done,
  output logic                   success,
  output logic                   full_reject,
  output logic [COUNT_OUT_W-1:0] entry_count,
  output logic                   empty_res
);

  localparam int CW = $clog2(ENTRIES + 1);

  logic               req_valid;
  ost_cmd_t           req_cmd;
  logic [VALUE_W-1:0] req_value;
  logic [CW-1:0]      count;
  logic [CW-1:0]      count_next;

  logic [ENTRIES:0]   chain;
  logic [VALUE_W-1:0] entry_q [ENTRIES];
  ost_bcast_t         bcast;
  logic               found;
  logic               full;
  logic               add_ok;
  logic               ok;
  logic               rej;

  // The chain end tells whether any live cell holds the value.
  assign chain[0] = 1'b0;
  assign found    = chain[ENTRIES];
  assign full     = (count == CW'(ENTRIES));
  assign add_ok   = req_valid && (req_cmd == CMD_ADD) && !found && !full;

  assign bcast.remove_go = req_valid && (req_cmd == CMD_REMOVE);
  assign bcast.value     = req_value;

  // Row of cells; cell i is live while i is below the count, and the append lands at count.
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    localparam logic [CW-1:0] IDX = CW'(i);
    logic [VALUE_W-1:0] next_entry;

    if (i == ENTRIES - 1) begin : g_top
      assign next_entry = entry_q[i];
    end else begin : g_mid
      assign next_entry = entry_q[i+1];
    end

    ost_cell u_cell (
      .clk        (clk),
      .bcast      (bcast),
      .occupied   (IDX < count),
      .write_here (add_ok && (count == IDX)),
      .shift_in   (chain[i]),
      .next_entry (next_entry),
      .entry      (entry_q[i]),
      .shift_out  (chain[i+1])
    );
  end

  // Outcome and new count of the command in the chain stage.
  always_comb begin
    count_next = count;
    ok         = 1'b0;
    rej        = 1'b0;
    case (req_cmd)
      CMD_ADD: begin
        if (!found) begin
          if (full) begin
            rej = 1'b1;
          end else begin
            ok         = 1'b1;
            count_next = count + CW'(1);
          end
        end
      end
      CMD_REMOVE: begin
        if (found) begin
          ok         = 1'b1;
          count_next = count - CW'(1);
        end
      end
      CMD_QUERY: begin
        ok = found;
      end
      CMD_CLEAR: begin
        ok         = 1'b1;
        count_next = '0;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  // Command register, count and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b1;
      req_valid <= 1'b0;
      count     <= '0;
      done      <= 1'b0;
    end else begin
      busy      <= 1'b0;
      req_valid <= start && !busy;
      done      <= req_valid;
      if (start && !busy) begin
        req_cmd   <= ost_cmd_t'(command);
        req_value <= value;
      end
      if (req_valid) begin
        count       <= count_next;
        success     <= ok;
        full_reject <= rej;
        entry_count <= COUNT_OUT_W'(count_next);
        empty_res   <= (count_next == '0);
      end
    end
  end

endmodule

@@ design/ost_checker.sv @@
// Port-level checker of the ordered set table and its bind to the top level.
`include "ordered_set_table_core_macros.svh"

module ost_checker
  import ost_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   start,
  input logic                   busy,
  input logic [CMD_W-1:0]       command,
  input logic                   done,
  input logic                   success,
  input logic                   full_reject
);

  // Every accepted transaction yields its result on done at the table's result latency.
  `OST_ASSERT_LAT2(a_result_follows, start && !busy, done, "accepted command gave no result")

  // A result is only shown for a transaction accepted at the result latency before it.
  `OST_ASSERT_NOW(a_no_spurious, done, $past(start && !busy, 2), "result without a command")

  // A rejected add never also reports success.
  `OST_ASSERT_NOW(a_reject_excl, done, !(success && full_reject), "success and full_reject")

  // A clear always succeeds and is never flagged as a reject.
  `OST_ASSERT_NOW(a_clear_empties, done && ($past(command, 2) == CMD_CLEAR),
    success && !full_reject, "clear did not succeed")

endmodule

bind ordered_set_table_core ost_checker u_ost_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .command     (command),
  .done        (done),
  .success     (success),
  .full_reject (full_reject)
);

@@ verif/tb_top.sv @@
// Self-checking testbench for the ordered set table core: directed and random command traffic.
`timescale 1ns / 1ps

module tb_top;
  import ost_pkg::*;

  localparam int TABLE_DEPTH    = OST_ENTRIES;
  localparam int RANDOM_OPS     = 750;
  localparam int WATCHDOG_LIMIT = 500;
  localparam int SETTLE_CYCLES  = 8;
  localparam int POOL_SIZE      = 40;

  // One command transaction waiting to be sent.
  typedef struct {
    ost_cmd_t           cmd;
    logic [VALUE_W-1:0] val;
    bit                 wait_idle;
  } set_op_t;

  // One expected result transaction.
  typedef struct {
    logic                   success;
    logic                   full_reject;
    logic [COUNT_OUT_W-1:0] entry_count;
    logic                   empty_res;
  } set_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic [CMD_W-1:0]       command = CMD_ADD;
  logic [VALUE_W-1:0]     value = '0;
  logic                   busy;
  logic                   done;
  logic                   success;
  logic                   full_reject;
  logic [COUNT_OUT_W-1:0] entry_count;
  logic                   empty_res;

  set_op_t     op_queue[$];
  set_result_t pending_results[$];
  int          mismatch_count = 0;
  int          idle_cycles = 0;
  int          burst_left = 1;
  int          gap_left = 0;

  // Shadow copy of the table contents, kept in insertion order.
  logic [VALUE_W-1:0] shadow_vals[TABLE_DEPTH];
  int                 shadow_count = 0;

  ordered_set_table_core u_top (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .command     (command),
    .value       (value),
    .done        (done),
    .success     (success),
    .full_reject (full_reject),
    .entry_count (entry_count),
    .empty_res   (empty_res)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Applies one command to the shadow table and returns the result it should produce.
  function automatic set_result_t apply_set_op(ost_cmd_t cmd, logic [VALUE_W-1:0] val);
    set_result_t r;
    int          pos;
    pos = -1;
    r.success = 1'b0;
    r.full_reject = 1'b0;
    for (int i = 0; i < shadow_count; i++) begin
      if (pos < 0 && shadow_vals[i] == val) pos = i;
    end
    case (cmd)
      CMD_ADD: begin
        if (pos < 0) begin
          if (shadow_count >= TABLE_DEPTH) begin
            r.full_reject = 1'b1;
          end else begin
            shadow_vals[shadow_count] = val;
            shadow_count++;
            r.success = 1'b1;
          end
        end
      end
      CMD_REMOVE: begin
        if (pos >= 0) begin
          for (int i = pos; i + 1 < shadow_count; i++) shadow_vals[i] = shadow_vals[i + 1];
          shadow_count--;
          r.success = 1'b1;
        end
      end
      CMD_QUERY: begin
        r.success = (pos >= 0);
      end
      default: begin
        shadow_count = 0;
        r.success = 1'b1;
      end
    endcase
    r.entry_count = shadow_count[COUNT_OUT_W-1:0];
    r.empty_res = (shadow_count == 0);
    return r;
  endfunction

  task automatic queue_op(ost_cmd_t cmd, logic [VALUE_W-1:0] val, bit wait_idle = 1'b0);
    set_op_t op;
    op.cmd = cmd;
    op.val = val;
    op.wait_idle = wait_idle;
    op_queue.push_back(op);
  endtask

  // Driver: predicts each accepted transaction and presents the next one in bursts.
  always @(posedge clk) begin
    logic    next_start;
    set_op_t op;
    next_start = 1'b0;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        pending_results.push_back(apply_set_op(ost_cmd_t'(command), value));
      end
      if (start && busy) begin
        next_start = 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (op_queue.size() > 0 &&
                   (!op_queue[0].wait_idle || pending_results.size() == 0)) begin
        op = op_queue.pop_front();
        command <= op.cmd;
        value <= op.val;
        next_start = 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
      start <= next_start;
    end
  end

  // Monitor: compares each result transaction with the oldest expectation.
  always @(posedge clk) begin
    set_result_t exp_r;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("Result transaction arrived with no command outstanding");
        mismatch_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (success !== exp_r.success) begin
          $error("success: expected %0d, got %0d", exp_r.success, success);
          mismatch_count++;
        end
        if (full_reject !== exp_r.full_reject) begin
          $error("full_reject: expected %0d, got %0d", exp_r.full_reject, full_reject);
          mismatch_count++;
        end
        if (entry_count !== exp_r.entry_count) begin
          $error("entry_count: expected %0d, got %0d", exp_r.entry_count, entry_count);
          mismatch_count++;
        end
        if (empty_res !== exp_r.empty_res) begin
          $error("empty_res: expected %0d, got %0d", exp_r.empty_res, empty_res);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: ends the run when nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [VALUE_W-1:0] value_pool[POOL_SIZE];
    logic [VALUE_W-1:0] fill_vals[TABLE_DEPTH];
    int                 target;
    int                 seg_len;
    int                 pick;
    int                 roll;

    // Directed part: extremes, duplicates, shifts on remove, clear and the empty table.
    queue_op(CMD_QUERY, 32'h0000_0000);
    queue_op(CMD_REMOVE, 32'h0000_0007);
    queue_op(CMD_ADD, 32'h8000_0000);
    queue_op(CMD_ADD, 32'h7fff_ffff);
    queue_op(CMD_ADD, 32'h0000_0000);
    queue_op(CMD_ADD, 32'hffff_ffff);
    queue_op(CMD_ADD, 32'h7fff_ffff);
    queue_op(CMD_QUERY, 32'h8000_0000);
    queue_op(CMD_QUERY, 32'h1234_5678);
    queue_op(CMD_REMOVE, 32'h0000_0000);
    queue_op(CMD_QUERY, 32'h0000_0000);
    queue_op(CMD_REMOVE, 32'h0000_0000);
    queue_op(CMD_QUERY, 32'hffff_ffff);
    queue_op(CMD_ADD, 32'h5555_5555);
    queue_op(CMD_ADD, 32'haaaa_aaaa);
    queue_op(CMD_REMOVE, 32'h8000_0000);
    queue_op(CMD_REMOVE, 32'haaaa_aaaa);
    queue_op(CMD_QUERY, 32'h7fff_ffff);
    queue_op(CMD_CLEAR, $urandom);
    queue_op(CMD_QUERY, 32'h7fff_ffff);
    queue_op(CMD_CLEAR, $urandom);
    queue_op(CMD_ADD, 32'h0000_0001);

    // A small pool of values makes adds, removes and queries hit often.
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7fff_ffff;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hffff_ffff;
    for (int i = 4; i < POOL_SIZE; i++) value_pool[i] = $urandom;

    // Random part, built from segments; its first command waits until every earlier result has come back.
    target = op_queue.size() + RANDOM_OPS;
    queue_op(CMD_QUERY, value_pool[$urandom_range(0, POOL_SIZE - 1)], 1'b1);
    while (op_queue.size() < target) begin
      roll = $urandom_range(0, 9);
      if (roll < 2) begin
        // Fill the table to capacity, then probe the full-table behavior.
        queue_op(CMD_CLEAR, $urandom, ($urandom_range(0, 4) == 0));
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          fill_vals[i] = $urandom;
          queue_op(CMD_ADD, fill_vals[i]);
        end
        queue_op(CMD_ADD, $urandom);
        queue_op(CMD_ADD, fill_vals[$urandom_range(0, TABLE_DEPTH - 1)]);
        queue_op(CMD_QUERY, fill_vals[$urandom_range(0, TABLE_DEPTH - 1)]);
        queue_op(CMD_QUERY, $urandom);
        pick = $urandom_range(0, TABLE_DEPTH - 1);
        queue_op(CMD_REMOVE, fill_vals[pick]);
        queue_op(CMD_QUERY, fill_vals[pick]);
        queue_op(CMD_ADD, $urandom);
        queue_op(CMD_ADD, $urandom);
        queue_op(CMD_REMOVE, fill_vals[0]);
        queue_op(CMD_REMOVE, fill_vals[TABLE_DEPTH - 1]);
      end else if (roll < 8) begin
        // Mixed traffic on the small pool.
        seg_len = $urandom_range(20, 60);
        for (int i = 0; i < seg_len; i++) begin
          pick = $urandom_range(0, 99);
          if (pick < 42) queue_op(CMD_ADD, value_pool[$urandom_range(0, POOL_SIZE - 1)]);
          else if (pick < 67) queue_op(CMD_REMOVE, value_pool[$urandom_range(0, POOL_SIZE - 1)]);
          else if (pick < 97) queue_op(CMD_QUERY, value_pool[$urandom_range(0, POOL_SIZE - 1)]);
          else queue_op(CMD_CLEAR, $urandom);
        end
      end else begin
        // Noise: any command with any value.
        seg_len = $urandom_range(5, 20);
        for (int i = 0; i < seg_len; i++) begin
          queue_op(ost_cmd_t'($urandom_range(0, 3)), $urandom,
                   (i == 0 && $urandom_range(0, 2) == 0));
        end
      end
    end

    // Reset, then let the driver and monitor run until everything has come back.
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    while (op_queue.size() > 0 || start || pending_results.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+design
design/ost_pkg.sv
design/ost_cell.sv
design/ordered_set_table_core.sv
design/ost_checker.sv
verif/tb_top.sv
